// ===== rtl/ufid_pkg.sv =====
package ufid_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_W            = 64;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_QUERY    = 2'd1,
        ACT_RETIRE   = 2'd2,
        ACT_LIST     = 2'd3
    } t_action;

    typedef struct packed {
        logic exec;
        logic list_step;
        logic list_last;
    } t_cmd;

    typedef struct packed {
        logic empty;
    } t_status;

endpackage

// ===== rtl/ufid_req_if.sv =====
interface ufid_req_if;
    import ufid_pkg::*;

    logic            valid;
    logic            ready;
    logic [1:0]      action;
    logic [ID_W-1:0] flow_id;

    modport source (output valid, output action, output flow_id, input ready);
    modport sink   (input valid, input action, input flow_id, output ready);
endinterface

// ===== rtl/ufid_rsp_if.sv =====
interface ufid_rsp_if;
    import ufid_pkg::*;

    logic            valid;
    logic            ready;
    logic            ok;
    logic [ID_W-1:0] listed_id;
    logic            entry_valid;
    logic            last;

    modport source (output valid, output ok, output listed_id, output entry_valid,
                    output last, input ready);
    modport sink   (input valid, input ok, input listed_id, input entry_valid,
                    input last, output ready);
endinterface

// ===== rtl/unique_flow_id_registry.sv =====
// A register, query or retire result is registered, valid in the cycle after its item is accepted.
// Throughput: one register, query or retire item per cycle while results are taken and no list runs.
// List of n stored entries: after acceptance the list state registers one entry result per cycle
// while results are taken; no item is taken until the list ends; an empty table answers in the next cycle.
// Reset clears the entry count and the handshake state; table contents stay undefined.
module unique_flow_id_registry #(
    parameter int TABLE_DEPTH = ufid_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ufid_req_if.sink   i_req,
    ufid_rsp_if.source o_rsp
);
    import ufid_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_cmd          w_cmd;
    t_status       w_status;
    t_action       w_action;
    logic [CW-1:0] w_count;

    assign w_action = t_action'(i_req.action);

    ufid_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_action    (w_action),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_count     (w_count),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ufid_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_action      (w_action),
        .i_flow_id     (i_req.flow_id),
        .o_count       (w_count),
        .o_status      (w_status),
        .o_ok          (o_rsp.ok),
        .o_listed_id   (o_rsp.listed_id),
        .o_entry_valid (o_rsp.entry_valid),
        .o_last        (o_rsp.last)
    );

endmodule

// ===== rtl/ufid_ctrl.sv =====
module ufid_ctrl #(
    parameter int TABLE_DEPTH = ufid_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ufid_pkg::t_action                i_action,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0] i_count,
    input  ufid_pkg::t_status                i_status,
    output ufid_pkg::t_cmd                   o_cmd
);
    import ufid_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_left, n_left;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;
    logic            w_accept;
    logic            w_list;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_list     = (i_action == ACT_LIST) && !i_status.empty;

    assign o_cmd.exec      = w_accept && !w_list;
    assign o_cmd.list_step = (r_state == ST_LIST) && w_out_free;
    assign o_cmd.list_last = (r_left == CW'(1));
    assign o_out_valid     = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.exec || o_cmd.list_step) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_list) begin
                    n_state = ST_LIST;
                    n_left  = i_count;
                end
            end
            ST_LIST: begin
                if (o_cmd.list_step) begin
                    n_left = r_left - CW'(1);
                    if (o_cmd.list_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    a_list_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LIST |-> !o_in_ready)
        else $error("input taken during list");

    a_list_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LIST |-> r_left != '0)
        else $error("list running with nothing left");

    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.list_step && o_cmd.list_last |=> r_state == ST_IDLE)
        else $error("list did not end after last entry");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec || o_cmd.list_step |=> r_out_valid)
        else $error("result loaded without valid");

endmodule

// ===== rtl/ufid_datapath.sv =====
module ufid_datapath #(
    parameter int TABLE_DEPTH = ufid_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ufid_pkg::t_cmd                   i_cmd,
    input  ufid_pkg::t_action                i_action,
    input  logic [ufid_pkg::ID_W-1:0]        i_flow_id,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_count,
    output ufid_pkg::t_status                o_status,
    output logic                             o_ok,
    output logic [ufid_pkg::ID_W-1:0]        o_listed_id,
    output logic                             o_entry_valid,
    output logic                             o_last
);
    import ufid_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [ID_W-1:0]        r_entry [TABLE_DEPTH];
    logic [ID_W-1:0]        n_entry [TABLE_DEPTH];
    logic [CW-1:0]          r_count, n_count;
    logic [TABLE_DEPTH-1:0] w_match;
    logic [TABLE_DEPTH-1:0] w_ge;
    logic                   w_hit;
    logic                   w_full;
    logic                   w_add;
    logic                   w_ok;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_match[i] = (CW'(i) < r_count) && (r_entry[i] == i_flow_id);
        end
    end

    // first match and everything above it
    assign w_ge   = (~w_match) + {{(TABLE_DEPTH-1){1'b0}}, 1'b1};
    assign w_hit  = |w_match;
    assign w_full = (r_count == CW'(TABLE_DEPTH));
    assign w_add  = !w_hit && !w_full;

    always_comb begin
        unique case (i_action)
            ACT_REGISTER: w_ok = w_add;
            ACT_QUERY:    w_ok = w_hit;
            ACT_RETIRE:   w_ok = w_hit;
            ACT_LIST:     w_ok = 1'b0;
            default:      w_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_entry = r_entry;
        if (i_cmd.list_step) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (CW'(i + 1) == r_count) begin
                    n_entry[i] = r_entry[0];
                end else if (CW'(i + 1) < r_count) begin
                    n_entry[i] = r_entry[(i + 1) % TABLE_DEPTH];
                end
            end
        end else if (i_cmd.exec) begin
            if (i_action == ACT_REGISTER && w_add) begin
                n_count = r_count + CW'(1);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (r_count == CW'(i)) begin
                        n_entry[i] = i_flow_id;
                    end
                end
            end else if (i_action == ACT_RETIRE && w_hit) begin
                n_count = r_count - CW'(1);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (w_ge[i]) begin
                        n_entry[i] = r_entry[(i + 1) % TABLE_DEPTH];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_cmd.list_step) begin
            o_ok          <= 1'b0;
            o_listed_id   <= r_entry[0];
            o_entry_valid <= 1'b1;
            o_last        <= i_cmd.list_last;
        end else if (i_cmd.exec) begin
            o_ok          <= w_ok;
            o_listed_id   <= '0;
            o_entry_valid <= 1'b0;
            o_last        <= 1'b1;
        end
    end

    assign o_count        = r_count;
    assign o_status.empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_register_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && i_action == ACT_REGISTER && w_add
        |=> r_count == $past(r_count) + CW'(1))
        else $error("register did not grow the table");

    a_retire_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && i_action == ACT_RETIRE && w_hit
        |=> r_count == $past(r_count) - CW'(1))
        else $error("retire did not shrink the table");

    a_list_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.list_step |=> r_count == $past(r_count))
        else $error("entry count changed during list");

endmodule
